FILE: hdl/pecs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pecs_pkg
// Shared constants, codes and helper functions of the pair edge counter.
// ----------------------------------------------------------------------------
package pecs_pkg;

  localparam int NODES      = 32;
  localparam int COUNT_BITS = 16;

  localparam int DIM      = 2 * NODES;
  localparam int CELLS    = DIM * DIM;
  localparam int DIM_W    = $clog2(DIM);
  localparam int ADDR_W   = $clog2(CELLS);
  localparam int K_W      = $clog2(CELLS + 1);
  localparam int CONTIG_W = 5;
  localparam int TYPE_W   = 3;
  localparam int MODE_W   = 2;
  localparam int NUM_W    = 13;
  localparam int THR_W    = 16;
  localparam int PCT_MUL  = DIM * (DIM - 1);
  localparam int PCT_DIV  = 100;
  localparam int PROD_W   = $clog2(PCT_MUL + 1) + NUM_W;
  localparam int BIT_W    = $clog2(COUNT_BITS);

  // Division by 100 is a shift by two followed by an exact reciprocal
  // multiplication for the remaining factor of 25.
  localparam int     RECIP_DIV   = PCT_DIV / 4;
  localparam int     RECIP_SHIFT = PROD_W - 2 + $clog2(RECIP_DIV);
  localparam longint RECIP_MUL   = ((longint'(1) << RECIP_SHIFT) + RECIP_DIV - 1) / RECIP_DIV;
  localparam int     RECIP_W     = $clog2(RECIP_MUL + 1);
  localparam int     RPROD_W     = PROD_W - 2 + RECIP_W;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [THR_W-1:0]      THR_MAX   = {THR_W{1'b1}};

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_SELECT = 1'b1;

  localparam logic [MODE_W-1:0] MODE_RANK_DIM = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RANK_NUM = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PERCENT  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_KEEP     = 2'd3;

  localparam logic [TYPE_W-1:0] PT_END      = 3'd2;
  localparam logic [TYPE_W-1:0] PT_END_LEFT = 3'd3;
  localparam logic [TYPE_W-1:0] PT_FWD      = 3'd4;
  localparam logic [TYPE_W-1:0] PT_FWD_LEFT = 3'd5;

  typedef struct packed {
    logic clear;
    logic issue;
    logic diag;
  } tally_ctl_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [DIM_W-1:0] row,
                                                  input logic [DIM_W-1:0] col);
    cell_addr = ADDR_W'(32'(row) * DIM + 32'(col));
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    sat_inc = (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [THR_W-1:0] to_thr(input logic [COUNT_BITS-1:0] v);
    if (v == '0) begin
      to_thr = THR_W'(1);
    end else if (32'(v) > 32'(THR_MAX)) begin
      to_thr = THR_MAX;
    end else begin
      to_thr = THR_W'(v);
    end
  endfunction

endpackage
`default_nettype wire

FILE: hdl/pecs_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pecs_in_if / pecs_out_if
// Valid/ready channels that carry commands in and thresholds out.
// ----------------------------------------------------------------------------
interface pecs_in_if;
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic [pecs_pkg::TYPE_W-1:0]   type_a;
  logic [pecs_pkg::TYPE_W-1:0]   type_b;
  logic [pecs_pkg::CONTIG_W-1:0] contig_a;
  logic [pecs_pkg::CONTIG_W-1:0] contig_b;
  logic [pecs_pkg::MODE_W-1:0]   select_mode;
  logic [pecs_pkg::NUM_W-1:0]    select_num;

  modport source (output valid, command, type_a, type_b, contig_a, contig_b,
                  select_mode, select_num, input ready);
  modport sink (input valid, command, type_a, type_b, contig_a, contig_b,
                select_mode, select_num, output ready);
endinterface

interface pecs_out_if;
  logic                       valid;
  logic                       ready;
  logic [pecs_pkg::THR_W-1:0] threshold;

  modport source (output valid, threshold, input ready);
  modport sink (input valid, threshold, output ready);
endinterface
`default_nettype wire

FILE: hdl/pecs_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pecs_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module pecs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic      [WIDTH-1:0]         rdata_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_b
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule
`default_nettype wire

FILE: hdl/pecs_tally.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pecs_tally
// Shared mask-and-compare unit: counts masked cells at or above a candidate.
// ----------------------------------------------------------------------------
module pecs_tally (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire pecs_pkg::tally_ctl_t                ctl,
  input  wire logic [pecs_pkg::COUNT_BITS-1:0]     cand,
  input  wire logic [pecs_pkg::COUNT_BITS-1:0]     fwd,
  input  wire logic [pecs_pkg::COUNT_BITS-1:0]     rev,
  output logic      [pecs_pkg::K_W-1:0]            count
);
  import pecs_pkg::*;

  logic           issue_d_r;
  logic           diag_d_r;
  logic [K_W-1:0] count_r;
  logic           hit;

  // The read data follow the issued address in the next cycle, so issue and diag are registered to match.
  assign hit = issue_d_r && !diag_d_r && ({fwd, 1'b0} >= {1'b0, rev}) && (fwd >= cand);
  assign count = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_d_r <= 1'b0;
      diag_d_r  <= 1'b0;
      count_r   <= '0;
    end else begin
      issue_d_r <= ctl.issue;
      diag_d_r  <= ctl.diag;
      if (ctl.clear) begin
        count_r <= '0;
      end else if (hit) begin
        count_r <= count_r + 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

FILE: hdl/pair_edge_counter_threshold_select_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pair_edge_counter_threshold_select_top
// Saturating edge-counter matrix with k-th largest threshold selection.
// ----------------------------------------------------------------------------
// After reset the block clears its 4096-entry counter memory, one entry per
// cycle, and accepts no transaction until that clearing is done. An add-edge
// transaction steps through acceptance, a paired read of both cells on the
// two-port memory, and one write per cell. A select transaction builds the
// threshold one bit at a time from the most significant bit; each of the
// COUNT_BITS passes sweeps the whole matrix through the shared compare unit,
// one cell and its reverse cell per cycle. Acceptance and the rank arithmetic
// come before the passes, and the hand-off to the output register after them;
// a keep request goes from acceptance straight to that hand-off. One
// transaction is in work at a time; a finished threshold waits in the output
// register while the next command is taken.
module pair_edge_counter_threshold_select_top (
  input  wire logic clk,
  input  wire logic rst_n,
  pecs_in_if.sink   in_ch,
  pecs_out_if.source out_ch
);
  import pecs_pkg::*;

  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_ADD    = 4'd2;
  localparam logic [3:0] S_ADD_W0 = 4'd3;
  localparam logic [3:0] S_ADD_W1 = 4'd4;
  localparam logic [3:0] S_MUL    = 4'd5;
  localparam logic [3:0] S_DIV    = 4'd6;
  localparam logic [3:0] S_KSET   = 4'd7;
  localparam logic [3:0] S_SCAN   = 4'd8;
  localparam logic [3:0] S_DRAIN  = 4'd9;
  localparam logic [3:0] S_STEP   = 4'd10;
  localparam logic [3:0] S_DONE   = 4'd11;

  logic [3:0]            state_r,   state_nxt;
  logic [ADDR_W-1:0]     clr_r,     clr_nxt;
  logic [ADDR_W-1:0]     cell0_r,   cell0_nxt;
  logic [ADDR_W-1:0]     cell1_r,   cell1_nxt;
  logic [COUNT_BITS-1:0] hold_r,    hold_nxt;
  logic [NUM_W-1:0]      num_r,     num_nxt;
  logic [PROD_W-1:0]     qd_r,      qd_nxt;
  logic [K_W-1:0]        k_r,       k_nxt;
  logic [COUNT_BITS-1:0] lo_r,      lo_nxt;
  logic [BIT_W-1:0]      bit_r,     bit_nxt;
  logic [DIM_W-1:0]      i_r,       i_nxt;
  logic [DIM_W-1:0]      j_r,       j_nxt;
  logic [THR_W-1:0]      thr_r,     thr_nxt;
  logic                  ovalid_r,  ovalid_nxt;
  logic [THR_W-1:0]      othr_r,    othr_nxt;

  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata;
  logic [ADDR_W-1:0]     ram_raddr_a;
  logic [ADDR_W-1:0]     ram_raddr_b;
  logic [COUNT_BITS-1:0] ram_rdata_a;
  logic [COUNT_BITS-1:0] ram_rdata_b;

  tally_ctl_t            tctl;
  logic [COUNT_BITS-1:0] cand;
  logic [K_W-1:0]        tally_count;

  logic                  pair_ok;
  logic [DIM_W-1:0]      r0, c0, r1, c1;
  logic [DIM_W-1:0]      a_lo, a_hi, b_lo, b_hi;
  logic [RPROD_W-1:0]    recip_prod;
  logic [COUNT_BITS-1:0] lo_new;
  logic                  accept;

  assign accept       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = ovalid_r;
  assign out_ch.threshold = othr_r;

  assign cand = lo_r | (COUNT_BITS'(1) << bit_r);

  // Placement-type pair decode into the two counter cells.
  always_comb begin
    a_lo = DIM_W'(in_ch.contig_a);
    b_lo = DIM_W'(in_ch.contig_b);
    a_hi = a_lo + DIM_W'(NODES);
    b_hi = b_lo + DIM_W'(NODES);
    pair_ok = 1'b1;
    r0 = a_lo;
    c0 = b_lo;
    r1 = b_hi;
    c1 = a_hi;
    case ({in_ch.type_a, in_ch.type_b})
      {PT_END_LEFT, PT_FWD}: begin
        r0 = a_lo; c0 = b_lo; r1 = b_hi; c1 = a_hi;
      end
      {PT_FWD, PT_END_LEFT}, {PT_FWD_LEFT, PT_END}, {PT_END, PT_FWD_LEFT}: begin
        r0 = b_lo; c0 = a_lo; r1 = a_hi; c1 = b_hi;
      end
      {PT_FWD_LEFT, PT_FWD}: begin
        r0 = a_hi; c0 = b_lo; r1 = b_hi; c1 = a_lo;
      end
      {PT_FWD, PT_FWD_LEFT}: begin
        r0 = b_hi; c0 = a_lo; r1 = a_hi; c1 = b_lo;
      end
      {PT_END_LEFT, PT_END}: begin
        r0 = a_lo; c0 = b_hi; r1 = b_lo; c1 = a_hi;
      end
      {PT_END, PT_END_LEFT}: begin
        r0 = b_lo; c0 = a_hi; r1 = a_lo; c1 = b_hi;
      end
      default: begin
        pair_ok = 1'b0;
      end
    endcase
    if ((in_ch.contig_a == in_ch.contig_b) || (32'(in_ch.contig_a) >= NODES) ||
        (32'(in_ch.contig_b) >= NODES)) begin
      pair_ok = 1'b0;
    end
  end

  assign recip_prod = RPROD_W'(qd_r[PROD_W-1:2]) * RPROD_W'(RECIP_MUL);
  assign lo_new     = (tally_count >= k_r) ? cand : lo_r;

  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    cell0_nxt  = cell0_r;
    cell1_nxt  = cell1_r;
    hold_nxt   = hold_r;
    num_nxt    = num_r;
    qd_nxt     = qd_r;
    k_nxt      = k_r;
    lo_nxt     = lo_r;
    bit_nxt    = bit_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    thr_nxt    = thr_r;
    othr_nxt   = othr_r;
    ovalid_nxt = ovalid_r && !out_ch.ready;
    case (state_r)
      S_CLR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == ADDR_W'(CELLS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (in_ch.command == CMD_ADD) begin
            cell0_nxt = cell_addr(r0, c0);
            cell1_nxt = cell_addr(r1, c1);
            if (pair_ok) begin
              state_nxt = S_ADD;
            end
          end else begin
            num_nxt = in_ch.select_num;
            case (in_ch.select_mode)
              MODE_RANK_DIM: begin
                qd_nxt    = PROD_W'(DIM - 2);
                state_nxt = S_KSET;
              end
              MODE_RANK_NUM: begin
                qd_nxt    = PROD_W'(in_ch.select_num);
                state_nxt = S_KSET;
              end
              MODE_PERCENT: begin
                state_nxt = S_MUL;
              end
              default: begin
                state_nxt = S_DONE;
              end
            endcase
          end
        end
      end
      S_ADD: begin
        state_nxt = S_ADD_W0;
      end
      S_ADD_W0: begin
        hold_nxt  = ram_rdata_b;
        state_nxt = S_ADD_W1;
      end
      S_ADD_W1: begin
        state_nxt = S_IDLE;
      end
      S_MUL: begin
        qd_nxt    = PROD_W'(PCT_MUL) * PROD_W'(num_r);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        qd_nxt    = PROD_W'(recip_prod >> RECIP_SHIFT);
        state_nxt = S_KSET;
      end
      S_KSET: begin
        if (qd_r == '0) begin
          k_nxt = K_W'(1);
        end else if (qd_r > PROD_W'(CELLS)) begin
          k_nxt = K_W'(CELLS);
        end else begin
          k_nxt = K_W'(qd_r);
        end
        lo_nxt    = '0;
        bit_nxt   = BIT_W'(COUNT_BITS - 1);
        i_nxt     = '0;
        j_nxt     = '0;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (j_r == DIM_W'(DIM - 1)) begin
          j_nxt = '0;
          if (i_r == DIM_W'(DIM - 1)) begin
            state_nxt = S_DRAIN;
          end else begin
            i_nxt = i_r + 1'b1;
          end
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      S_DRAIN: begin
        state_nxt = S_STEP;
      end
      S_STEP: begin
        lo_nxt = lo_new;
        i_nxt  = '0;
        j_nxt  = '0;
        if (bit_r == '0) begin
          thr_nxt   = to_thr(lo_new);
          state_nxt = S_DONE;
        end else begin
          bit_nxt   = bit_r - 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_DONE: begin
        if (!ovalid_r || out_ch.ready) begin
          ovalid_nxt = 1'b1;
          othr_nxt   = thr_r;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_r;
    ram_wdata = '0;
    case (state_r)
      S_CLR: begin
        ram_we = 1'b1;
      end
      S_ADD_W0: begin
        ram_we    = 1'b1;
        ram_waddr = cell0_r;
        ram_wdata = sat_inc(ram_rdata_a);
      end
      S_ADD_W1: begin
        ram_we    = 1'b1;
        ram_waddr = cell1_r;
        ram_wdata = sat_inc(hold_r);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  assign ram_raddr_a = (state_r == S_ADD) ? cell0_r : cell_addr(i_r, j_r);
  assign ram_raddr_b = (state_r == S_ADD) ? cell1_r : cell_addr(j_r, i_r);

  assign tctl.clear = (state_r == S_KSET) || (state_r == S_STEP);
  assign tctl.issue = (state_r == S_SCAN);
  assign tctl.diag  = (i_r == j_r);

  pecs_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (CELLS)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .rdata_a (ram_rdata_a),
    .raddr_b (ram_raddr_b),
    .rdata_b (ram_rdata_b)
  );

  pecs_tally u_tally (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (tctl),
    .cand  (cand),
    .fwd   (ram_rdata_a),
    .rev   (ram_rdata_b),
    .count (tally_count)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLR;
      clr_r    <= '0;
      ovalid_r <= 1'b0;
      thr_r    <= '0;
      bit_r    <= '0;
      i_r      <= '0;
      j_r      <= '0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      ovalid_r <= ovalid_nxt;
      thr_r    <= thr_nxt;
      bit_r    <= bit_nxt;
      i_r      <= i_nxt;
      j_r      <= j_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cell0_r <= cell0_nxt;
    cell1_r <= cell1_nxt;
    hold_r  <= hold_nxt;
    num_r   <= num_nxt;
    qd_r    <= qd_nxt;
    k_r     <= k_nxt;
    lo_r    <= lo_nxt;
    othr_r  <= othr_nxt;
  end

  // A pass can never count more cells than the matrix holds.
  a_tally_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tally_count <= K_W'(CELLS))
    else $error("tally count exceeds the number of cells");

  // The counter memory is written only by the clearing pass or an edge add.
  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_CLR || state_r == S_ADD_W0 || state_r == S_ADD_W1))
    else $error("counter memory written outside clear or add");

  // The last bit pass always hands the threshold to the output stage.
  a_last_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STEP && bit_r == '0) |=> (state_r == S_DONE))
    else $error("final pass did not finish the select transaction");

endmodule
`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for pair_edge_counter_threshold_select_top. A queue of commands
// feeds a clocked driver, and a local model of the counter matrix predicts
// each returned threshold. A clocked monitor checks every result against the
// oldest prediction. The run covers directed cases, a burst on one cell
// pair, random traffic under several idle patterns and a long output stall.
// ----------------------------------------------------------------------------
module tb;
  import pecs_pkg::*;

  typedef struct {
    logic                command;
    logic [TYPE_W-1:0]   type_a;
    logic [TYPE_W-1:0]   type_b;
    logic [CONTIG_W-1:0] contig_a;
    logic [CONTIG_W-1:0] contig_b;
    logic [MODE_W-1:0]   select_mode;
    logic [NUM_W-1:0]    select_num;
  } command_t;

  localparam int IDLE_LIMIT = 400000;

  logic clk;
  logic rst_n;

  pecs_in_if  in_ch();
  pecs_out_if out_ch();

  pair_edge_counter_threshold_select_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  command_t            pending_cmds[$];
  logic [THR_W-1:0]    expected_thr[$];
  logic [COUNT_BITS-1:0] matrix[CELLS];
  logic [THR_W-1:0]    model_thr;
  int                  sender_idle_pct;
  int                  receiver_stall_pct;
  int                  hold_left;
  int                  idle_cycles;
  int                  errors;
  int                  adds_sent;
  int                  selects_sent;
  int                  results_seen;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.command     = CMD_ADD;
    in_ch.type_a      = '0;
    in_ch.type_b      = '0;
    in_ch.contig_a    = '0;
    in_ch.contig_b    = '0;
    in_ch.select_mode = MODE_KEEP;
    in_ch.select_num  = '0;
    out_ch.ready      = 1'b0;
  end

  function automatic void bump_cell(int row, int col);
    if (matrix[row * DIM + col] != COUNT_MAX) begin
      matrix[row * DIM + col] = matrix[row * DIM + col] + 1'b1;
    end
  endfunction

  function automatic void apply_pair(command_t c);
    int a;
    int b;
    a = c.contig_a;
    b = c.contig_b;
    if (a == b) begin
      return;
    end
    case ({c.type_a, c.type_b})
      {PT_END_LEFT, PT_FWD}: begin
        bump_cell(a, b); bump_cell(b + NODES, a + NODES);
      end
      {PT_FWD, PT_END_LEFT}: begin
        bump_cell(b, a); bump_cell(a + NODES, b + NODES);
      end
      {PT_FWD_LEFT, PT_FWD}: begin
        bump_cell(a + NODES, b); bump_cell(b + NODES, a);
      end
      {PT_FWD, PT_FWD_LEFT}: begin
        bump_cell(b + NODES, a); bump_cell(a + NODES, b);
      end
      {PT_END_LEFT, PT_END}: begin
        bump_cell(a, b + NODES); bump_cell(b, a + NODES);
      end
      {PT_END, PT_END_LEFT}: begin
        bump_cell(b, a + NODES); bump_cell(a, b + NODES);
      end
      {PT_FWD_LEFT, PT_END}, {PT_END, PT_FWD_LEFT}: begin
        bump_cell(b, a); bump_cell(a + NODES, b + NODES);
      end
      default: begin
      end
    endcase
  endfunction

  function automatic logic [THR_W-1:0] rank_threshold(command_t c);
    longint k;
    int     vals[CELLS];
    int     cnt;
    int     rev;
    int     v;
    if (c.select_mode == MODE_KEEP) begin
      return model_thr;
    end
    if (c.select_mode == MODE_RANK_DIM) begin
      k = DIM - 2;
    end else if (c.select_mode == MODE_RANK_NUM) begin
      k = c.select_num;
    end else begin
      k = longint'(DIM) * (DIM - 1) * c.select_num / 100;
    end
    if (k < 1) k = 1;
    if (k > CELLS) k = CELLS;
    for (int i = 0; i < DIM; i++) begin
      for (int j = 0; j < DIM; j++) begin
        cnt = matrix[i * DIM + j];
        rev = matrix[j * DIM + i];
        vals[i * DIM + j] = (i == j || 2 * cnt < rev) ? 0 : cnt;
      end
    end
    vals.rsort();
    v = vals[k - 1];
    if (v < 1) v = 1;
    if (v > 65535) v = 65535;
    return THR_W'(v);
  endfunction

  // Driver: a new command is offered once the previous one is taken.
  always @(posedge clk) begin
    command_t c;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_cmds.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
        c = pending_cmds.pop_front();
        in_ch.valid       <= 1'b1;
        in_ch.command     <= c.command;
        in_ch.type_a      <= c.type_a;
        in_ch.type_b      <= c.type_b;
        in_ch.contig_a    <= c.contig_a;
        in_ch.contig_b    <= c.contig_b;
        in_ch.select_mode <= c.select_mode;
        in_ch.select_num  <= c.select_num;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Accepted commands update the local matrix and predict thresholds.
  always @(posedge clk) begin
    command_t c;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      c.command     = in_ch.command;
      c.type_a      = in_ch.type_a;
      c.type_b      = in_ch.type_b;
      c.contig_a    = in_ch.contig_a;
      c.contig_b    = in_ch.contig_b;
      c.select_mode = in_ch.select_mode;
      c.select_num  = in_ch.select_num;
      if (c.command == CMD_ADD) begin
        apply_pair(c);
        adds_sent++;
      end else begin
        model_thr = rank_threshold(c);
        expected_thr.push_back(model_thr);
        selects_sent++;
      end
    end
  end

  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: checks each threshold transaction against the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_thr.size() == 0) begin
          $display("%0t: unexpected threshold, expected none, actual %0d", $time,
                   out_ch.threshold);
          errors++;
        end else if (expected_thr[0] !== out_ch.threshold) begin
          $display("%0t: threshold mismatch, expected %0d, actual %0d", $time,
                   expected_thr[0], out_ch.threshold);
          errors++;
          void'(expected_thr.pop_front());
        end else begin
          void'(expected_thr.pop_front());
        end
      end
      out_ch.ready <= (hold_left > 0) ? 1'b0 : ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout after %0d cycles without a transaction.", IDLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic command_t make_add(int ta, int tb, int a, int b);
    command_t c;
    c.command     = CMD_ADD;
    c.type_a      = TYPE_W'(ta);
    c.type_b      = TYPE_W'(tb);
    c.contig_a    = CONTIG_W'(a);
    c.contig_b    = CONTIG_W'(b);
    c.select_mode = MODE_W'($urandom_range(3));
    c.select_num  = NUM_W'($urandom_range(8191));
    return c;
  endfunction

  function automatic command_t make_select(logic [MODE_W-1:0] mode, int num);
    command_t c;
    c.command     = CMD_SELECT;
    c.type_a      = TYPE_W'($urandom_range(7));
    c.type_b      = TYPE_W'($urandom_range(7));
    c.contig_a    = CONTIG_W'($urandom_range(31));
    c.contig_b    = CONTIG_W'($urandom_range(31));
    c.select_mode = mode;
    c.select_num  = NUM_W'(num);
    return c;
  endfunction

  function automatic command_t random_add();
    logic [TYPE_W-1:0] listed[16];
    int pick;
    int a;
    listed = '{PT_END_LEFT, PT_FWD, PT_FWD, PT_END_LEFT, PT_FWD_LEFT, PT_FWD,
               PT_FWD, PT_FWD_LEFT, PT_END_LEFT, PT_END, PT_END, PT_END_LEFT,
               PT_FWD_LEFT, PT_END, PT_END, PT_FWD_LEFT};
    a = $urandom_range(31);
    if ($urandom_range(99) < 80) begin
      pick = $urandom_range(7);
      // A small contig pool concentrates counts so that ranks differ.
      return make_add(listed[2 * pick], listed[2 * pick + 1], $urandom_range(7),
                      ($urandom_range(9) == 0) ? a : $urandom_range(31));
    end
    return make_add($urandom_range(7), $urandom_range(7), a, $urandom_range(31));
  endfunction

  // Waits until every queued transaction is accepted and every result seen.
  task automatic drain();
    @(negedge clk);
    while (pending_cmds.size() > 0 || in_ch.valid || expected_thr.size() > 0) begin
      @(negedge clk);
    end
    repeat (10) @(posedge clk);
  endtask

  task automatic random_phase(int sender_pct, int receiver_pct, int n, bit full_select);
    sender_idle_pct    = sender_pct;
    receiver_stall_pct = receiver_pct;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 12) begin
        pending_cmds.push_back(make_select(MODE_KEEP, $urandom_range(8191)));
      end else begin
        pending_cmds.push_back(random_add());
      end
    end
    if (full_select) begin
      pending_cmds.push_back(make_select(MODE_W'($urandom_range(2)),
                                         $urandom_range(4096)));
    end
    drain();
  endtask

  initial begin
    idle_cycles        = 0;
    errors             = 0;
    adds_sent          = 0;
    selects_sent       = 0;
    results_seen       = 0;
    hold_left          = 0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    model_thr          = '0;
    for (int i = 0; i < CELLS; i++) matrix[i] = '0;
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    pending_cmds.push_back(make_select(MODE_KEEP, 0));
    pending_cmds.push_back(make_add(PT_END_LEFT, PT_FWD, 0, 31));
    pending_cmds.push_back(make_add(PT_FWD, PT_END_LEFT, 31, 0));
    pending_cmds.push_back(make_add(PT_FWD_LEFT, PT_FWD, 1, 2));
    pending_cmds.push_back(make_add(PT_FWD, PT_FWD_LEFT, 2, 3));
    pending_cmds.push_back(make_add(PT_END_LEFT, PT_END, 3, 4));
    pending_cmds.push_back(make_add(PT_END, PT_END_LEFT, 4, 5));
    pending_cmds.push_back(make_add(PT_FWD_LEFT, PT_END, 5, 6));
    pending_cmds.push_back(make_add(PT_END, PT_FWD_LEFT, 6, 7));
    pending_cmds.push_back(make_add(PT_END_LEFT, PT_FWD, 9, 9));
    pending_cmds.push_back(make_add(7, 0, 10, 11));
    pending_cmds.push_back(make_add(0, 7, 11, 10));
    pending_cmds.push_back(make_add(PT_END_LEFT, PT_FWD, 0, 31));
    pending_cmds.push_back(make_add(PT_FWD, PT_END_LEFT, 0, 31));
    pending_cmds.push_back(make_select(MODE_RANK_DIM, 0));
    pending_cmds.push_back(make_select(MODE_RANK_NUM, 0));
    pending_cmds.push_back(make_select(MODE_RANK_NUM, 4096));
    pending_cmds.push_back(make_select(MODE_PERCENT, 0));
    pending_cmds.push_back(make_select(MODE_PERCENT, 100));
    pending_cmds.push_back(make_select(MODE_KEEP, 8191));
    drain();

    // One cell pair collects a large count that dominates the top rank.
    for (int i = 0; i < 150; i++) begin
      pending_cmds.push_back(make_add(PT_END_LEFT, PT_FWD, 12, 13));
    end
    pending_cmds.push_back(make_select(MODE_RANK_NUM, 1));
    drain();

    random_phase(0, 0, 330, 1'b0);

    // The output stays blocked while keep requests pile up at the input.
    hold_left = 3000;
    for (int i = 0; i < 40; i++) begin
      pending_cmds.push_back(make_select(MODE_KEEP, $urandom_range(8191)));
    end
    drain();

    random_phase(47, 0, 330, 1'b1);
    random_phase(0, 47, 330, 1'b0);
    random_phase(18, 18, 330, 1'b1);

    repeat (50) @(posedge clk);
    $display("Run covered %0d edge adds and %0d select commands, %0d thresholds checked.",
             adds_sent, selects_sent, results_seen);
    $display("Phases: directed, one heavy cell pair, four idle patterns and a long output stall.");
    if (errors == 0 && expected_thr.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("Failures: %0d, thresholds still expected: %0d", errors, expected_thr.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
